>>> hdl/pef_pkg.sv
`timescale 1ns / 1ps
// pef_pkg: shared types and constants of the pose ema outlier filter
// no dependencies; used by the lanes, the merge stage and the top level

package pef_pkg;

  // register indexes on the configuration channel
  localparam logic [1:0] CFG_FILTER_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_SMOOTHING_GAIN = 2'd1;
  localparam logic [1:0] CFG_JUMP_LIMIT     = 2'd2;

  // gain of 1.0 in q1.16
  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  // reset values of the registers
  localparam logic [16:0] GAIN_RESET     = 17'd6554;
  localparam logic [30:0] LIMIT_RESET    = 31'd9830;
  localparam logic [61:0] LIMIT_SQ_RESET = 62'd96628900;

  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_PRIME  = 2'd1,
    KIND_SNAP   = 2'd2,
    KIND_SMOOTH = 2'd3
  } update_kind_t;

  // what one axis lane finds
  typedef struct packed {
    logic        over;    // |raw - est| beyond the jump limit
    logic [61:0] sq;      // squared distance, valid when not over
    logic [31:0] smooth;  // estimate after one smoothing step
  } lane_res_t;

  // decision of the merge stage
  typedef struct packed {
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  z;
    update_kind_t kind;
    logic         upd_est;
    logic         primed;
  } merge_res_t;

endpackage

>>> hdl/pef_if.sv
`timescale 1ns / 1ps
// pef_if: valid/ready channels of the pose ema outlier filter
// raw pose requests, filtered pose requests and register writes; no dependencies

interface pef_raw_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] raw_x;
  logic signed [31:0] raw_y;
  logic signed [31:0] raw_z;
  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface pef_filt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filt_x;
  logic signed [31:0] filt_y;
  logic signed [31:0] filt_z;
  logic        [1:0]  update_kind;
  modport source (output valid, output filt_x, output filt_y, output filt_z,
                  output update_kind, input ready);
  modport sink   (input valid, input filt_x, input filt_y, input filt_z,
                  input update_kind, output ready);
endinterface

interface pef_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> hdl/pose_ema_outlier_filter.sv
`timescale 1ns / 1ps
// pose_ema_outlier_filter: top level, registers, estimate state and output stage
// depends on pef_pkg, pef_if, pef_lane and pef_merge

// channel     dir  payload                                   accepted when
// pose_in     in   raw_x, raw_y, raw_z (q16.16)              valid & ready
// filt_pose   out  filt_x, filt_y, filt_z, update_kind       valid & ready
// cfg         in   reg_index, wdata                          valid & ready (always ready)
//
// one request per cycle; the whole update (three axis lanes plus merge) runs in the
// cycle of acceptance and lands in the output register and the estimate at that edge
// the estimate feedback loop (subtract, square, sum, compare, select) sets the cycle time
// a result appears in the cycle after its request; pose_in.ready drops only while the
// output register holds a result that filt_pose does not take
// synchronous reset: registers to their reset values, estimate zero, not primed

module pose_ema_outlier_filter
  import pef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pef_raw_if.sink    pose_in,
  pef_filt_if.source filt_pose,
  pef_cfg_if.sink    cfg
);

  // configuration
  logic        enable;
  logic [16:0] alpha;     // kept clamped to one
  logic [30:0] limit;
  logic [61:0] limit_sq;  // square of limit, formed on write

  // filter state
  logic signed [31:0] est_x;
  logic signed [31:0] est_y;
  logic signed [31:0] est_z;
  logic               primed;

  // output register
  logic               out_valid;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  update_kind_t       out_kind;

  logic       acc;
  logic       cfg_wr;
  lane_res_t  lane_x_res;
  lane_res_t  lane_y_res;
  lane_res_t  lane_z_res;
  merge_res_t merged;

  // register write port, never stalls
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b0;
      alpha    <= GAIN_RESET;
      limit    <= LIMIT_RESET;
      limit_sq <= LIMIT_SQ_RESET;
    end else if (cfg_wr) begin
      unique case (cfg.reg_index)
        CFG_FILTER_ENABLE: enable <= cfg.wdata[0];
        CFG_SMOOTHING_GAIN: begin
          // gains above one act as one
          alpha <= (cfg.wdata[16:0] > ALPHA_ONE) ? ALPHA_ONE : cfg.wdata[16:0];
        end
        CFG_JUMP_LIMIT: begin
          limit    <= cfg.wdata[30:0];
          limit_sq <= {31'd0, cfg.wdata[30:0]} * {31'd0, cfg.wdata[30:0]};
        end
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // take a request whenever the output register is free or drains this cycle
  assign pose_in.ready = !out_valid || filt_pose.ready;
  assign acc           = pose_in.valid && pose_in.ready;

  // one lane per axis
  pef_lane lane_x (
    .raw   (pose_in.raw_x),
    .est   (est_x),
    .alpha (alpha),
    .limit (limit),
    .res   (lane_x_res)
  );

  pef_lane lane_y (
    .raw   (pose_in.raw_y),
    .est   (est_y),
    .alpha (alpha),
    .limit (limit),
    .res   (lane_y_res)
  );

  pef_lane lane_z (
    .raw   (pose_in.raw_z),
    .est   (est_z),
    .alpha (alpha),
    .limit (limit),
    .res   (lane_z_res)
  );

  // jump guard and choice of update
  pef_merge merge (
    .enable   (enable),
    .primed   (primed),
    .limit_nz (limit != '0),
    .limit_sq (limit_sq),
    .raw_x    (pose_in.raw_x),
    .raw_y    (pose_in.raw_y),
    .raw_z    (pose_in.raw_z),
    .lane_x   (lane_x_res),
    .lane_y   (lane_y_res),
    .lane_z   (lane_z_res),
    .res      (merged)
  );

  // estimate and primed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      est_x  <= '0;
      est_y  <= '0;
      est_z  <= '0;
      primed <= 1'b0;
    end else if (acc) begin
      primed <= merged.primed;
      if (merged.upd_est) begin
        est_x <= merged.x;
        est_y <= merged.y;
        est_z <= merged.z;
      end
    end
  end

  // output register: valid clears under reset, payload loads on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (filt_pose.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_x    <= merged.x;
      out_y    <= merged.y;
      out_z    <= merged.z;
      out_kind <= merged.kind;
    end
  end

  assign filt_pose.valid       = out_valid;
  assign filt_pose.filt_x      = out_x;
  assign filt_pose.filt_y      = out_y;
  assign filt_pose.filt_z      = out_z;
  assign filt_pose.update_kind = out_kind;

  // checks

  // a request while disabled leaves the filter unprimed
  a_disable_clears : assert property (@(posedge clk) disable iff (rst)
    (acc && !enable) |=> !primed)
    else $error("primed flag survived a disabled request");

  // primed only rises through an enabled request
  a_prime_source : assert property (@(posedge clk) disable iff (rst)
    $rose(primed) |-> $past(acc && enable))
    else $error("primed rose without an enabled request");

  // snap or smooth only happen on a primed estimate
  a_kind_primed : assert property (@(posedge clk) disable iff (rst)
    (acc && ((merged.kind == KIND_SNAP) || (merged.kind == KIND_SMOOTH))) |-> primed)
    else $error("snap or smooth on an unprimed estimate");

  // every request leaves a result in the output register
  a_result_held : assert property (@(posedge clk) disable iff (rst)
    acc |=> out_valid)
    else $error("accepted request produced no result");

  // stored gain never exceeds one
  a_gain_clamped : assert property (@(posedge clk) disable iff (rst)
    alpha <= ALPHA_ONE)
    else $error("smoothing gain above one");

endmodule

>>> hdl/pef_lane.sv
`timescale 1ns / 1ps
// pef_lane: one axis of the filter, distance test terms and smoothing step
// depends on pef_pkg

module pef_lane
  import pef_pkg::*;
(
  input  logic signed [31:0] raw,
  input  logic signed [31:0] est,
  input  logic        [16:0] alpha,
  input  logic        [30:0] limit,
  output lane_res_t          res
);

  logic signed [32:0] diff;
  logic        [32:0] mag;
  logic        [30:0] mag_lo;
  logic signed [50:0] prod;

  always_comb begin
    diff   = {raw[31], raw} - {est[31], est};
    mag    = diff[32] ? 33'(-diff) : 33'(diff);
    mag_lo = mag[30:0];
    // alpha is nonnegative, extend it with a zero sign bit
    prod   = $signed({1'b0, alpha}) * diff;

    res.over   = mag > {2'b00, limit};
    res.sq     = {31'd0, mag_lo} * {31'd0, mag_lo};
    // est + (prod >>> 16), kept to 32 bits
    res.smooth = 32'(est) + prod[47:16];
  end

endmodule

>>> hdl/pef_merge.sv
`timescale 1ns / 1ps
// pef_merge: joins the three lanes, runs the jump guard and picks the update
// depends on pef_pkg

module pef_merge
  import pef_pkg::*;
(
  input  logic               enable,
  input  logic               primed,
  input  logic               limit_nz,
  input  logic        [61:0] limit_sq,
  input  logic signed [31:0] raw_x,
  input  logic signed [31:0] raw_y,
  input  logic signed [31:0] raw_z,
  input  lane_res_t          lane_x,
  input  lane_res_t          lane_y,
  input  lane_res_t          lane_z,
  output merge_res_t         res
);

  logic [63:0] sum;
  logic        trip;

  always_comb begin
    sum  = {2'b00, lane_x.sq} + {2'b00, lane_y.sq} + {2'b00, lane_z.sq};
    trip = limit_nz &&
           (lane_x.over || lane_y.over || lane_z.over || (sum > {2'b00, limit_sq}));

    res.x       = raw_x;
    res.y       = raw_y;
    res.z       = raw_z;
    res.kind    = KIND_PASS;
    res.upd_est = 1'b0;
    res.primed  = 1'b0;
    priority if (!enable) begin
      res.kind = KIND_PASS;
    end else if (!primed) begin
      res.kind    = KIND_PRIME;
      res.upd_est = 1'b1;
      res.primed  = 1'b1;
    end else if (trip) begin
      res.kind    = KIND_SNAP;
      res.upd_est = 1'b1;
      res.primed  = 1'b1;
    end else begin
      res.x       = lane_x.smooth;
      res.y       = lane_y.smooth;
      res.z       = lane_z.smooth;
      res.kind    = KIND_SMOOTH;
      res.upd_est = 1'b1;
      res.primed  = 1'b1;
    end
  end

endmodule

>>> tb/tb_pose_ema_outlier_filter.sv
`timescale 1ns / 1ps
// tb_pose_ema_outlier_filter: self-checking bench for the pose ema outlier filter
// depends on pef_pkg, pef_if and pose_ema_outlier_filter; a local predictor checks every result

module tb_pose_ema_outlier_filter;
  import pef_pkg::*;

  // index with no register behind it, writes to it must change nothing
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    int unsigned        gap;   // cycles the sender idles before offering this request
  } raw_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    update_kind_t       kind;
  } pose_t;

  logic clk;
  logic rst;

  pef_raw_if  raw_ch ();
  pef_filt_if filt_ch ();
  pef_cfg_if  cfg_ch ();

  pose_ema_outlier_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .pose_in   (raw_ch),
    .filt_pose (filt_ch),
    .cfg       (cfg_ch)
  );

  // clock, 20 ns period
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // requests waiting to be offered, and filtered poses waiting to be seen
  raw_req_t raw_pending[$];
  pose_t    filt_expected[$];

  // handshake flags passed from the sampling edge to the driving edge
  bit raw_taken;
  bit filt_taken;
  bit raw_busy;
  int unsigned ready_hold;

  // per-phase switches that turn idling off on either side
  bit calm_send;
  bit calm_recv;

  int err_count;

  // predicted register contents
  logic        cfg_enable;
  logic [16:0] cfg_gain;
  logic [30:0] cfg_limit;

  // predicted estimate state
  logic [31:0] est_pos_x;
  logic [31:0] est_pos_y;
  logic [31:0] est_pos_z;
  logic        est_valid;

  task automatic report(input string msg);
    // keep the log short when something is badly broken, but count everything
    if (err_count < 40) $display("ERROR %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic cfg_apply(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_FILTER_ENABLE:  cfg_enable = data[0];
      CFG_SMOOTHING_GAIN: cfg_gain   = data[16:0];
      CFG_JUMP_LIMIT:     cfg_limit  = data[30:0];
      default: ;
    endcase
  endtask

  // est + floor(alpha * d / 2^16), arithmetic shift on a wide product
  function automatic logic [31:0] ema_move(input logic [31:0] est,
                                           input logic signed [32:0] d,
                                           input logic [16:0] alpha);
    longint prod;
    longint step;
    prod = longint'(alpha) * longint'(d);
    step = prod >>> 16;
    return est + step[31:0];
  endfunction

  // one accepted raw pose: update the predicted state and queue the filtered pose
  task automatic filter_step(input logic signed [31:0] rx,
                             input logic signed [31:0] ry,
                             input logic signed [31:0] rz);
    pose_t              res;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic [32:0]        az;
    logic [63:0]        dist_sq;
    logic [63:0]        lim_sq;
    logic [16:0]        alpha;
    logic               jump;
    if (!cfg_enable) begin
      // passthrough, the estimate is kept but no longer trusted
      est_valid = 1'b0;
      res = '{rx, ry, rz, KIND_PASS};
    end else if (!est_valid) begin
      // first enabled sample seeds the estimate
      est_pos_x = rx;
      est_pos_y = ry;
      est_pos_z = rz;
      est_valid = 1'b1;
      res = '{rx, ry, rz, KIND_PRIME};
    end else begin
      // differences at 33 bits so extreme jumps do not wrap
      dx = {rx[31], rx} - {est_pos_x[31], est_pos_x};
      dy = {ry[31], ry} - {est_pos_y[31], est_pos_y};
      dz = {rz[31], rz} - {est_pos_z[31], est_pos_z};
      ax = dx[32] ? (~dx + 33'd1) : dx;
      ay = dy[32] ? (~dy + 33'd1) : dy;
      az = dz[32] ? (~dz + 33'd1) : dz;
      jump = 1'b0;
      if (cfg_limit != 31'd0) begin
        if (ax > cfg_limit || ay > cfg_limit || az > cfg_limit) begin
          jump = 1'b1;
        end else begin
          // every axis is within the limit here, so each square is below 2^62
          dist_sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az);
          lim_sq  = 64'(cfg_limit) * 64'(cfg_limit);
          jump = dist_sq > lim_sq;
        end
      end
      if (jump) begin
        est_pos_x = rx;
        est_pos_y = ry;
        est_pos_z = rz;
        res = '{rx, ry, rz, KIND_SNAP};
      end else begin
        // gains above one behave as one
        alpha = (cfg_gain > ALPHA_ONE) ? ALPHA_ONE : cfg_gain;
        est_pos_x = ema_move(est_pos_x, dx, alpha);
        est_pos_y = ema_move(est_pos_y, dy, alpha);
        est_pos_z = ema_move(est_pos_z, dz, alpha);
        res = '{est_pos_x, est_pos_y, est_pos_z, KIND_SMOOTH};
      end
    end
    filt_expected = {filt_expected, res};
  endtask

  // sender: offers requests from the pending queue at falling edges
  always @(negedge clk) begin
    if (raw_taken) begin
      raw_taken = 1'b0;
      raw_busy  = 1'b0;
    end
    if (!raw_busy && raw_pending.size() > 0) begin
      if (raw_pending[0].gap == 0) begin
        raw_ch.raw_x <= raw_pending[0].x;
        raw_ch.raw_y <= raw_pending[0].y;
        raw_ch.raw_z <= raw_pending[0].z;
        raw_ch.valid <= 1'b1;
        void'(raw_pending.pop_front());
        raw_busy = 1'b1;
      end else begin
        raw_pending[0].gap--;
      end
    end
    // valid only drops when nothing is offered, so a back-to-back request keeps it high
    if (!raw_busy) raw_ch.valid <= 1'b0;
  end

  // receiver: draws a stall for every result it takes
  always @(negedge clk) begin
    if (filt_taken) begin
      filt_taken = 1'b0;
      ready_hold = calm_recv ? 0 : $urandom_range(0, 16);
    end
    if (ready_hold == 0) begin
      filt_ch.ready <= 1'b1;
    end else begin
      ready_hold--;
      filt_ch.ready <= 1'b0;
    end
  end

  // sampling at rising edges: register writes, results, then new requests
  always @(posedge clk) begin : monitor
    pose_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) cfg_apply(cfg_ch.reg_index, cfg_ch.wdata);
      // results are checked before the request of this edge is predicted
      if (filt_ch.valid && filt_ch.ready) begin
        filt_taken = 1'b1;
        if (filt_expected.size() == 0) begin
          report("filtered pose with no request pending");
        end else begin
          want = filt_expected.pop_front();
          if (filt_ch.filt_x !== want.x)
            report($sformatf("filt_x got %h want %h", filt_ch.filt_x, want.x));
          if (filt_ch.filt_y !== want.y)
            report($sformatf("filt_y got %h want %h", filt_ch.filt_y, want.y));
          if (filt_ch.filt_z !== want.z)
            report($sformatf("filt_z got %h want %h", filt_ch.filt_z, want.z));
          if (filt_ch.update_kind !== want.kind)
            report($sformatf("update_kind got %0d want %0d", filt_ch.update_kind, want.kind));
        end
      end
      if (raw_ch.valid && raw_ch.ready) begin
        filter_step(raw_ch.raw_x, raw_ch.raw_y, raw_ch.raw_z);
        raw_taken = 1'b1;
      end
    end
  end

  // watchdog on cycles in which no handshake of any kind happens
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst) begin
      if ((raw_ch.valid && raw_ch.ready) || (filt_ch.valid && filt_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("pose_ema_outlier_filter: mismatch");
        $finish;
      end
    end
  end

  task automatic push_raw(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic signed [31:0] z);
    raw_req_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.gap = calm_send ? 0 : $urandom_range(0, 16);
    raw_pending = {raw_pending, r};
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    cfg_ch.valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // drained: nothing left to offer, nothing outstanding, plus a few cycles of slack
  task automatic wait_idle();
    while (raw_pending.size() != 0 || raw_ch.valid || filt_expected.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int walk_x;
    int walk_y;
    int walk_z;
    int scale;
    int pick;
    logic [31:0] data;

    // every block input known from time zero
    rst = 1'b1;
    raw_ch.valid = 1'b0;
    raw_ch.raw_x = '0;
    raw_ch.raw_y = '0;
    raw_ch.raw_z = '0;
    filt_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wdata = '0;

    cfg_enable = 1'b0;
    cfg_gain   = GAIN_RESET;
    cfg_limit  = LIMIT_RESET;
    est_pos_x  = '0;
    est_pos_y  = '0;
    est_pos_z  = '0;
    est_valid  = 1'b0;

    calm_send = 1'b0;
    calm_recv = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // reset settings, filter off: extremes pass straight through
    push_raw(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_raw(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_raw(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    wait_idle();

    // filter on with reset gain and guard
    write_reg(CFG_FILTER_ENABLE, 32'd1);
    push_raw(32'd0, 32'd0, 32'd0);                   // primes the estimate
    push_raw(32'd100, -32'sd100, 32'd50);            // small move, smoothed
    push_raw(32'd200000, 32'd0, 32'd0);              // one axis beyond the guard, snap
    push_raw(32'd206000, 32'd6000, 32'd6000);        // axes inside, squared sum beyond, snap
    push_raw(32'd215830, 32'd6000, 32'd6000);        // distance exactly at the guard, smoothed
    push_raw(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000); // far jump, snap
    wait_idle();

    // guard off, gain of one: the estimate follows the widest possible jump
    write_reg(CFG_SMOOTHING_GAIN, 32'h0001_0000);
    write_reg(CFG_JUMP_LIMIT, 32'd0);
    push_raw(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_raw(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
    wait_idle();

    // gain above one behaves as one
    write_reg(CFG_SMOOTHING_GAIN, 32'h0001_FFFF);
    push_raw(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    wait_idle();

    // zero gain holds the estimate
    write_reg(CFG_SMOOTHING_GAIN, 32'd0);
    push_raw(32'd12345, -32'sd54321, 32'd999);
    wait_idle();

    // tiny gain, largest guard written with the top bit set
    write_reg(CFG_SMOOTHING_GAIN, 32'd1);
    write_reg(CFG_JUMP_LIMIT, 32'hFFFF_FFFF);
    push_raw(32'h7FFF_FFFF, 32'h8000_0000, 32'd12345);
    push_raw(32'h8000_0000, 32'h7FFF_FFFF, -32'sd1);
    push_raw(-32'sd1, -32'sd1, -32'sd1);
    wait_idle();

    // disable through an even value with high bits set, then clear of priming
    write_reg(CFG_FILTER_ENABLE, 32'hFFFF_FFFE);
    push_raw(32'd5, 32'd6, 32'd7);
    wait_idle();
    write_reg(CFG_FILTER_ENABLE, 32'd3);
    write_reg(CFG_UNUSED, $urandom);
    push_raw(32'd1, 32'd2, 32'd3);                   // primes again
    push_raw(32'd4, 32'd5, 32'd6);
    wait_idle();

    // --- random part: 14 phases of 100 requests, each with its own settings ---
    walk_x = $urandom;
    walk_y = $urandom;
    walk_z = $urandom;
    for (int ph = 0; ph < 14; ph++) begin
      wait_idle();
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);

      // mostly on; noise in the unused bits of the written word
      data = $urandom & 32'hFFFF_FFFE;
      data[0] = ($urandom_range(0, 9) < 8);
      write_reg(CFG_FILTER_ENABLE, data);

      case ($urandom_range(0, 5))
        0: data = 32'd0;
        1: data = 32'(ALPHA_ONE);
        2: data = $urandom_range(65537, 131071);
        3: data = $urandom_range(1, 64);
        4: data = $urandom_range(0, 65536);
        default: data = 32'(GAIN_RESET);
      endcase
      data = data | ($urandom & 32'hFFFE_0000);
      write_reg(CFG_SMOOTHING_GAIN, data);

      case ($urandom_range(0, 4))
        0: data = 32'd0;
        1: data = $urandom_range(1, 1 << 16);
        2: data = $urandom;
        3: data = 32'(LIMIT_RESET);
        default: data = $urandom_range(1 << 16, 1 << 24);
      endcase
      write_reg(CFG_JUMP_LIMIT, data);

      // step size of the walking trajectory for this phase
      case ($urandom_range(0, 3))
        0: scale = 8;
        1: scale = 500;
        2: scale = 20000;
        default: scale = 1 << 22;
      endcase

      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          // smooth trajectory, the bulk of the stimulus
          walk_x += int'($urandom_range(0, 2 * scale)) - scale;
          walk_y += int'($urandom_range(0, 2 * scale)) - scale;
          walk_z += int'($urandom_range(0, 2 * scale)) - scale;
          push_raw(walk_x, walk_y, walk_z);
        end else if (pick < 85) begin
          // trajectory jumps somewhere else
          walk_x = $urandom;
          walk_y = $urandom;
          walk_z = $urandom;
          push_raw(walk_x, walk_y, walk_z);
        end else begin
          // one-off outlier, the trajectory resumes after it
          push_raw($urandom, $urandom, $urandom);
        end
      end
    end

    wait_idle();
    if (filt_expected.size() != 0)
      report($sformatf("%0d filtered poses never arrived", filt_expected.size()));
    if (err_count == 0) begin
      $display("pose_ema_outlier_filter: match");
    end else begin
      $display("pose_ema_outlier_filter: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pef_pkg.sv
hdl/pef_if.sv
hdl/pef_lane.sv
hdl/pef_merge.sv
hdl/pose_ema_outlier_filter.sv
tb/tb_pose_ema_outlier_filter.sv
